// ----- rtl/core/rsa_pkg.sv -----
`default_nettype none
package rsa_pkg;

  localparam int SLOTS_DEFAULT = 4096;
  localparam int SLOT_MAX_W    = 16;

  localparam int INDEX_W = 31;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP  = 1'd1;

  localparam logic [INDEX_W-1:0] WINDOW_BASE_RESET = 31'd0;
  localparam logic [INDEX_W-1:0] WINDOW_TOP_RESET  = 31'd4095;

  localparam logic KIND_ACCUMULATE = 1'b0;
  localparam logic KIND_DRAIN      = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam int QUEUE_DEPTH = 2;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic                     kind;
    logic                     in_window;
    logic [SLOT_MAX_W-1:0]    slot;
    logic signed [VALUE_W-1:0] fine_value;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/rsa_if.sv -----
`default_nettype none
interface rsa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [30:0]                coarse_index;
  logic signed [31:0]         fine_value;

  modport source (output valid, kind, coarse_index, fine_value, input ready);
  modport sink   (input valid, kind, coarse_index, fine_value, output ready);
endinterface

interface rsa_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [47:0]         sum_value;
  logic                       in_window;
  logic                       saturated;

  modport source (output valid, sum_value, in_window, saturated, input ready);
  modport sink   (input valid, sum_value, in_window, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rsa_front.sv -----
`default_nettype none
module rsa_front #(
  parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire rsa_pkg::back_status_t           status,
  rsa_in_if.sink                               item,
  output      logic                            push_valid,
  input  wire logic                            push_ready,
  output      rsa_pkg::entry_t                 push_data
);
  import rsa_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [INDEX_W-1:0] SLOT_COUNT = INDEX_W'(SLOTS);

  logic [INDEX_W-1:0] window_base;
  logic [INDEX_W-1:0] window_top;
  logic [INDEX_W-1:0] rel;
  logic               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= WINDOW_BASE_RESET;
      window_top  <= WINDOW_TOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_BASE: window_base <= cfg_data;
        REG_WINDOW_TOP:  window_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  // An index past the end of the store counts as outside the window.
  always_comb begin
    rel = item.coarse_index - window_base;
    hit = (item.coarse_index >= window_base) && (item.coarse_index <= window_top) &&
          (rel < SLOT_COUNT);
  end

  assign item.ready = push_ready && !status.clearing;
  assign push_valid = item.valid && !status.clearing;

  always_comb begin
    push_data.kind       = item.kind;
    push_data.in_window  = hit;
    push_data.slot       = SLOT_MAX_W'(rel[SLOT_W-1:0]);
    push_data.fine_value = item.fine_value;
  end

endmodule
`default_nettype wire

// ----- rtl/core/rsa_queue.sv -----
`default_nettype none
module rsa_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output      logic            push_ready,
  input  wire rsa_pkg::entry_t push_data,
  output      logic            pop_valid,
  input  wire logic            pop_ready,
  output      rsa_pkg::entry_t pop_data
);
  import rsa_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] FULL = COUNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]   LAST = PTR_W'(QUEUE_DEPTH - 1);

  entry_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rsa_back.sv -----
`default_nettype none
module rsa_back #(
  parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output      logic            pop_ready,
  input  wire rsa_pkg::entry_t pop_data,
  output      rsa_pkg::back_status_t status,
  rsa_out_if.source            result
);
  import rsa_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [SUM_W-1:0]  mem [SLOTS];
  logic [SUM_W-1:0]  rd_data;
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] clear_addr;
  entry_t            cur;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;
  logic [SUM_W-1:0]  mem_wdata;

  logic [SUM_W:0]    total;
  logic              overflow;
  logic [SUM_W-1:0]  acc_value;

  logic              out_valid;
  logic [SUM_W-1:0]  out_sum;
  logic              out_in_window;
  logic              out_saturated;
  logic              out_free;

  assign out_free  = !out_valid || result.ready;
  assign pop_ready = (state == ST_IDLE);
  assign status.clearing = (state == ST_CLEAR);

  // Saturating add on a 49-bit sum; the top two bits differ on overflow.
  always_comb begin
    total     = {rd_data[SUM_W-1], rd_data} +
                {{(SUM_W + 1 - VALUE_W){cur.fine_value[VALUE_W-1]}}, cur.fine_value};
    overflow  = total[SUM_W] ^ total[SUM_W-1];
    acc_value = overflow ? (total[SUM_W] ? SUM_MIN : SUM_MAX) : total[SUM_W-1:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur.slot[SLOT_W-1:0];
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clear_addr;
    end else if (state == ST_EXEC && out_free && cur.in_window) begin
      mem_we    = 1'b1;
      mem_wdata = (cur.kind == KIND_ACCUMULATE) ? acc_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // The slot is read while in ST_READ and the data is held through ST_EXEC.
  always_ff @(posedge clk) begin
    rd_data <= mem[cur.slot[SLOT_W-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_addr == LAST_SLOT) state_next = ST_IDLE;
      ST_IDLE:  if (pop_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (state == ST_EXEC && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      cur <= pop_data;
    end
    if (state == ST_EXEC && out_free) begin
      out_in_window <= cur.in_window;
      out_sum       <= (cur.in_window && cur.kind == KIND_DRAIN) ? rd_data : '0;
      out_saturated <= cur.in_window && (cur.kind == KIND_ACCUMULATE) && overflow;
    end
  end

  assign result.valid     = out_valid;
  assign result.sum_value = out_sum;
  assign result.in_window = out_in_window;
  assign result.saturated = out_saturated;

endmodule
`default_nettype wire

// ----- rtl/core/ranged_scatter_accumulate.sv -----
`default_nettype none
// Scatter-add store of SLOTS signed Q32.16 sums, 48 bits each, addressed by a global coarse
// index through the window [window_base, window_top]. An accumulate beat adds its value to
// the slot with saturation; a drain beat returns the slot's sum and clears it. Every input beat
// yields exactly one result beat. Items are classified on entry and wait in a two-entry queue;
// the back end then handles one item at a time (pick up, read the store, update and write
// back) and takes up a new item only once the last is written back, while the queue still
// takes input; the write-back waits for a free output register, and the result beat is
// registered with it. After reset the store is cleared one slot a cycle, during which no
// item is accepted; configuration writes are taken at any time.
module ranged_scatter_accumulate #(
  parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  rsa_in_if.sink                               item,
  rsa_out_if.source                            result
);
  import rsa_pkg::*;

  back_status_t status;
  logic         push_valid;
  logic         push_ready;
  entry_t       push_data;
  logic         pop_valid;
  logic         pop_ready;
  entry_t       pop_data;

  rsa_front #(.SLOTS(SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rsa_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .status    (status),
    .result    (result)
  );

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> status.clearing)
    else $error("store clearing pass did not start after reset");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !item.ready)
    else $error("input beat offered a ready while the store is being cleared");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !result.valid && !pop_ready)
    else $error("back end active during the clearing pass");

  a_out_of_window_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.in_window) |-> (result.sum_value == '0) && !result.saturated)
    else $error("out-of-window result carries a sum or a saturation flag");

endmodule
`default_nettype wire

// ----- bench/tb_ranged_scatter_accumulate.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_ranged_scatter_accumulate;
  import rsa_pkg::*;

  localparam int SLOTS        = SLOTS_DEFAULT;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int PRINT_CAP    = 50;
  localparam int LARGE_RUN    = 40;

  typedef struct {
    logic                    kind;
    logic signed [SUM_W-1:0] sum_value;
    logic                    in_window;
    logic                    saturated;
  } slot_outcome_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rsa_in_if  item_if ();
  rsa_out_if result_if ();

  ranged_scatter_accumulate #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // Shadow of the coarse store and of the window registers.
  logic signed [SUM_W-1:0] coarse_shadow [SLOTS];
  logic [INDEX_W-1:0]      win_base;
  logic [INDEX_W-1:0]      win_top;
  slot_outcome_t           outcomes_due [$];

  int mismatches;
  int cycles;
  int pace_on;
  int hold_left;
  int n_accumulate;
  int n_drain;
  int n_outside;
  int n_clipped;
  int n_windows;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic slot_outcome_t accumulate_or_drain(input logic k,
                                                        input logic [INDEX_W-1:0] idx,
                                                        input logic signed [VALUE_W-1:0] v);
    slot_outcome_t     o;
    logic [31:0]       rel;
    logic [SLOT_W-1:0] slot;
    longint            s;
    o.kind      = k;
    o.sum_value = '0;
    o.in_window = 1'b0;
    o.saturated = 1'b0;
    rel  = {1'b0, idx} - {1'b0, win_base};
    slot = rel[SLOT_W-1:0];
    if (idx >= win_base && idx <= win_top && rel < SLOTS) begin
      o.in_window = 1'b1;
      if (k == KIND_ACCUMULATE) begin
        s = longint'(coarse_shadow[slot]) + longint'(v);
        if (s > longint'($signed(SUM_MAX))) begin
          s = longint'($signed(SUM_MAX));
          o.saturated = 1'b1;
        end else if (s < longint'($signed(SUM_MIN))) begin
          s = longint'($signed(SUM_MIN));
          o.saturated = 1'b1;
        end
        coarse_shadow[slot] = s[SUM_W-1:0];
      end else begin
        o.sum_value = coarse_shadow[slot];
        coarse_shadow[slot] = '0;
      end
    end
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Called right after a rising edge; returns at the edge that took the beat.
  task automatic send_item(input logic k, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= k;
    item_if.coarse_index <= idx;
    item_if.fine_value   <= v;
    do @(posedge clk); while (!item_if.ready);
    outcomes_due.push_back(accumulate_or_drain(k, idx, v));
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
  endtask

  task automatic set_window(input logic [INDEX_W-1:0] base, input logic [INDEX_W-1:0] top);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_BASE;
    cfg_data  <= base;
    @(posedge clk);
    win_base  = base;
    cfg_index <= REG_WINDOW_TOP;
    cfg_data  <= top;
    @(posedge clk);
    win_top   = top;
    cfg_we    <= 1'b0;
    n_windows++;
  endtask

  function automatic logic [INDEX_W-1:0] pick_coarse_index();
    int r;
    r = $urandom_range(0, 99);
    // Most beats land on a few hot slots so that drains return real sums.
    if (r < 50) return win_base + INDEX_W'($urandom_range(0, 23));
    if (r < 65) return win_base + INDEX_W'($urandom_range(0, SLOTS - 1));
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0: return win_base - INDEX_W'(1);
        1: return win_base;
        2: return win_top;
        3: return win_top + INDEX_W'(1);
        4: return win_base + INDEX_W'(SLOTS - 1);
        default: return win_base + INDEX_W'(SLOTS);
      endcase
    end
    return INDEX_W'($urandom());
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_fine_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 80) return VALUE_W'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
    if (r < 85) return 32'sh7FFF_FFFF;
    if (r < 90) return 32'sh8000_0000;
    return VALUE_W'($signed($urandom_range(0, 4)) - 2);
  endfunction

  task automatic test_reset_window();
    send_item(KIND_ACCUMULATE, 31'd0, 32'sh7FFF_FFFF);
    send_item(KIND_ACCUMULATE, 31'd0, 32'sh8000_0000);
    send_item(KIND_ACCUMULATE, 31'd4095, -32'sd65536);
    send_item(KIND_ACCUMULATE, 31'd4096, 32'sd12345);
    send_item(KIND_ACCUMULATE, 31'h7FFF_FFFF, -32'sd1);
    send_item(KIND_DRAIN, 31'd4096, 32'sd0);
    send_item(KIND_DRAIN, 31'd0, 32'sh1234_5678);
    // A second drain of the same slot must find it cleared.
    send_item(KIND_DRAIN, 31'd0, 32'sd0);
    send_item(KIND_DRAIN, 31'd4095, 32'sd0);
    send_item(KIND_ACCUMULATE, 31'd5, 32'sh5555_5555);
    send_item(KIND_ACCUMULATE, 31'd5, 32'shAAAA_AAAA);
    send_item(KIND_DRAIN, 31'd5, 32'sd0);
    settle();
  endtask

  task automatic test_window_edges();
    set_window(31'd1000, 31'd1100);
    send_item(KIND_ACCUMULATE, 31'd999, 32'sd1);
    send_item(KIND_ACCUMULATE, 31'd1000, 32'sd2);
    send_item(KIND_ACCUMULATE, 31'd1100, 32'sd3);
    send_item(KIND_ACCUMULATE, 31'd1101, 32'sd4);
    send_item(KIND_DRAIN, 31'd1000, 32'sd0);
    send_item(KIND_DRAIN, 31'd1100, 32'sd0);
    settle();
    set_window(31'h7FFF_F000, 31'h7FFF_FFFF);
    send_item(KIND_ACCUMULATE, 31'h7FFF_FFFF, 32'sh0001_8000);
    send_item(KIND_DRAIN, 31'h7FFF_FFFF, 32'sd0);
    send_item(KIND_DRAIN, 31'h7FFF_EFFF, 32'sd0);
    settle();
    // Base above top leaves the window empty.
    set_window(31'd5, 31'd4);
    send_item(KIND_ACCUMULATE, 31'd5, 32'sd77);
    send_item(KIND_DRAIN, 31'd4, 32'sd0);
    settle();
    // A window wider than the store: indices past the last slot are dropped.
    set_window(31'd100, 31'h7FFF_FFFF);
    send_item(KIND_ACCUMULATE, 31'd4195, 32'sd9);
    send_item(KIND_ACCUMULATE, 31'd4196, 32'sd10);
    send_item(KIND_DRAIN, 31'd4195, 32'sd0);
    settle();
    set_window(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(KIND_ACCUMULATE, 31'h7FFF_FFFF, -32'sd3);
    send_item(KIND_DRAIN, 31'h7FFF_FFFF, 32'sd0);
    settle();
  endtask

  task automatic test_large_values();
    int i;
    pace_on = 0;
    set_window(WINDOW_BASE_RESET, WINDOW_TOP_RESET);
    send_item(KIND_DRAIN, 31'd7, 32'sd0);
    // Full-scale values pile up well past 32 bits and must come back exactly.
    for (i = 0; i < LARGE_RUN; i++) send_item(KIND_ACCUMULATE, 31'd7, 32'sh7FFF_FFFF);
    send_item(KIND_ACCUMULATE, 31'd7, 32'sd1);
    send_item(KIND_ACCUMULATE, 31'd7, -32'sd1);
    send_item(KIND_DRAIN, 31'd7, 32'sd0);
    for (i = 0; i < LARGE_RUN; i++) send_item(KIND_ACCUMULATE, 31'd7, 32'sh8000_0000);
    send_item(KIND_ACCUMULATE, 31'd7, -32'sd1);
    send_item(KIND_DRAIN, 31'd7, 32'sd0);
    settle();
  endtask

  task automatic test_backpressure();
    int i;
    pace_on   = 0;
    hold_left = 300;
    for (i = 0; i < 40; i++)
      send_item(i % 5 == 4 ? KIND_DRAIN : KIND_ACCUMULATE,
                WINDOW_BASE_RESET + INDEX_W'(i % 6), pick_fine_value());
    settle();
  endtask

  task automatic test_random_traffic(input logic [INDEX_W-1:0] base,
                                     input logic [INDEX_W-1:0] top, input int count);
    int i;
    set_window(base, top);
    for (i = 0; i < count; i++) begin
      // Every third stretch of 64 beats runs without any idling.
      pace_on = int'(((i / 64) % 3) != 2);
      send_item($urandom_range(0, 3) == 0 ? KIND_DRAIN : KIND_ACCUMULATE,
                pick_coarse_index(), pick_fine_value());
    end
    settle();
  endtask

  initial begin : result_sink
    int stall_left;
    result_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (!pace_on) begin
        result_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : result_check
    slot_outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        if (outcomes_due.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", 1, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (result_if.sum_value !== want.sum_value)
            flag_mismatch("sum_value", longint'(result_if.sum_value),
                          longint'(want.sum_value));
          if (result_if.in_window !== want.in_window)
            flag_mismatch("in_window", longint'(result_if.in_window),
                          longint'(want.in_window));
          if (result_if.saturated !== want.saturated)
            flag_mismatch("saturated", longint'(result_if.saturated),
                          longint'(want.saturated));
          if (!want.in_window) n_outside++;
          else if (want.kind == KIND_DRAIN) n_drain++;
          else n_accumulate++;
          if (want.saturated) n_clipped++;
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sequence_tests
    int n;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_WINDOW_BASE;
    cfg_data             = '0;
    item_if.valid        = 1'b0;
    item_if.kind         = KIND_ACCUMULATE;
    item_if.coarse_index = '0;
    item_if.fine_value   = '0;
    win_base             = WINDOW_BASE_RESET;
    win_top              = WINDOW_TOP_RESET;
    pace_on              = 1;
    hold_left            = 0;
    mismatches           = 0;
    n_accumulate         = 0;
    n_drain              = 0;
    n_outside            = 0;
    n_clipped            = 0;
    n_windows            = 0;
    foreach (coarse_shadow[i]) coarse_shadow[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_window_edges();
    test_large_values();
    test_backpressure();
    pace_on = 1;
    test_random_traffic(WINDOW_BASE_RESET, WINDOW_TOP_RESET, 350);
    test_random_traffic(31'd1000, 31'd1100, 250);
    test_random_traffic(31'h7FFF_F000, 31'h7FFF_FFFF, 300);
    test_random_traffic(31'd200, 31'h7FFF_FFFF, 300);
    test_random_traffic(31'd7, 31'd3, 100);
    test_random_traffic(31'd0, 31'd0, 100);
    test_random_traffic(31'h7FFF_FFFF, 31'h7FFF_FFFF, 100);

    // Give any stray beat time to show up before the verdict.
    item_if.valid <= 1'b0;
    for (n = 0; n < 20000 && outcomes_due.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (outcomes_due.size() != 0)
      flag_mismatch("results still outstanding at the end", 0, outcomes_due.size());

    $display("Checked %0d in-window accumulates, %0d drains and %0d out-of-window beats.",
             n_accumulate, n_drain, n_outside);
    $display("Saw %0d clipped sums over %0d window settings; %0d mismatches.",
             n_clipped, n_windows, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- ranged_scatter_accumulate.f -----
rtl/core/rsa_pkg.sv
rtl/core/rsa_if.sv
rtl/core/rsa_front.sv
rtl/core/rsa_queue.sv
rtl/core/rsa_back.sv
rtl/core/ranged_scatter_accumulate.sv
bench/tb_ranged_scatter_accumulate.sv
